@@ design/atoi_pkg.sv @@
// Shared types, character codes and helper functions for the ASCII number converter.
package atoi_pkg;

  // Width of the converted value.
  localparam int ValueWidth = 32;

  // Character codes that steer the parser.
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_LOWER_X = 8'h78;
  localparam logic [7:0] CHAR_UPPER_X = 8'h58;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;

  // Parser modes, one-hot.
  typedef enum logic [5:0] {
    MODE_START = 6'b000001,
    MODE_ZERO  = 6'b000010,
    MODE_DEC   = 6'b000100,
    MODE_STOP  = 6'b001000,
    MODE_HEX   = 6'b010000,
    MODE_BAD   = 6'b100000
  } atoi_mode_t;

  // One converted result.
  typedef struct packed {
    logic signed [ValueWidth-1:0] number_value;
    logic                         is_hex;
  } atoi_result_t;

  // True for the characters '0' to '9'.
  function automatic logic is_dec_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'b0;
    if (is_dec_digit(c)) begin
      d = {1'b1, c[3:0]};
    end else if (((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F)) ||
                 ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F))) begin
      // 'a'/'A' end in 1, so adding nine gives ten upwards.
      d = {1'b1, c[3:0] + 4'd9};
    end
    return d;
  endfunction

endpackage

@@ design/atoi_if.sv @@
// Handshake interfaces for the character input and the result output.
interface atoi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface atoi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] number_value;
  logic               is_hex;

  modport source (output valid, output number_value, output is_hex, input ready);
  modport sink   (input valid, input number_value, input is_hex, output ready);
endinterface

@@ design/ascii_number_to_integer_core.sv @@
// Top level of the ASCII number converter: input register, parser and result register.
//
//   Channel   Dir   Payload                         Word accepted when
//   in_chan   in    char_code[7:0]                  valid && ready
//   out_chan  out   number_value[31:0], is_hex      valid && ready
//
// One character is taken every cycle while in_chan.ready is high; a character
// waits in the input register and its parser update is registered once it is processed.
// A terminator's result is written to the output register when the terminator is processed.
// Reset (rst_n low, synchronous) empties both registers and returns to the start state.
// Only a terminator waits for a full output register; other characters pass on.
// in_chan.ready drops only while a terminator waits behind an unread result.
module ascii_number_to_integer_core
  import atoi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  atoi_in_if.sink           in_chan,
  atoi_out_if.source        out_chan
);

  logic         in_valid_r;
  logic [7:0]   in_char_r;
  logic         out_valid_r;
  atoi_result_t out_data_r;

  atoi_result_t parse_res;
  logic         is_term;
  logic         proc;

  // A terminator needs the output register free; any other character does not.
  assign is_term = (in_char_r == CHAR_NUL);
  assign proc    = in_valid_r && (!is_term || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || proc;

  atoi_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (proc),
    .char_code (in_char_r),
    .result    (parse_res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_char_r <= in_chan.char_code;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && is_term) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && is_term) begin
      out_data_r <= parse_res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.number_value = out_data_r.number_value;
  assign out_chan.is_hex       = out_data_r.is_hex;

endmodule

@@ design/atoi_parse.sv @@
// Parser state and per-character update of mode, accumulator and sign.
module atoi_parse
  import atoi_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   char_code,
  output atoi_result_t result
);

  atoi_mode_t            mode_r, mode_nxt;
  logic [ValueWidth-1:0] acc_r, acc_nxt;
  logic                  neg_r, neg_nxt;

  logic [ValueWidth-1:0] acc_dec;
  logic [ValueWidth-1:0] acc_hex;
  logic [4:0]            hex_d;
  logic                  dec_ok;

  // Multiply-add by ten as two shifts, and by sixteen as a plain shift.
  always_comb begin
    dec_ok  = is_dec_digit(char_code);
    hex_d   = hex_digit(char_code);
    acc_dec = {acc_r[ValueWidth-4:0], 3'b000} + {acc_r[ValueWidth-2:0], 1'b0}
              + {{(ValueWidth-4){1'b0}}, char_code[3:0]};
    acc_hex = {acc_r[ValueWidth-5:0], hex_d[3:0]};
  end

  // Result seen when the current character is the terminator.
  always_comb begin
    result.is_hex = 1'b0;
    result.number_value = acc_r;
    if (mode_r == MODE_HEX) begin
      result.is_hex = 1'b1;
    end else if (mode_r == MODE_BAD) begin
      result.is_hex = 1'b1;
      result.number_value = '0;
    end else if (neg_r) begin
      result.number_value = -acc_r;
    end
  end

  // Next parser state.
  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    if (char_code == CHAR_NUL) begin
      mode_nxt = MODE_START;
      acc_nxt  = '0;
      neg_nxt  = 1'b0;
    end else begin
      case (mode_r)
        MODE_ZERO: begin
          if ((char_code == CHAR_LOWER_X) || (char_code == CHAR_UPPER_X)) begin
            mode_nxt = MODE_HEX;
            acc_nxt  = '0;
          end else if (dec_ok) begin
            mode_nxt = MODE_DEC;
            acc_nxt  = acc_dec;
          end else begin
            mode_nxt = MODE_STOP;
          end
        end
        MODE_DEC: begin
          if (dec_ok) begin
            acc_nxt = acc_dec;
          end else begin
            mode_nxt = MODE_STOP;
          end
        end
        MODE_STOP, MODE_BAD: begin
          mode_nxt = mode_r;
        end
        MODE_HEX: begin
          if (hex_d[4]) begin
            acc_nxt = acc_hex;
          end else begin
            mode_nxt = MODE_BAD;
            acc_nxt  = '0;
          end
        end
        default: begin
          // Start of string, and any code that should not arise.
          if (char_code == CHAR_MINUS) begin
            neg_nxt  = 1'b1;
            mode_nxt = MODE_DEC;
          end else if (char_code == CHAR_ZERO) begin
            acc_nxt  = '0;
            mode_nxt = MODE_ZERO;
          end else if (dec_ok) begin
            acc_nxt  = {{(ValueWidth-4){1'b0}}, char_code[3:0]};
            mode_nxt = MODE_DEC;
          end else begin
            mode_nxt = MODE_STOP;
          end
        end
      endcase
    end
  end

  // State registers advance once per processed word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_START;
      acc_r  <= '0;
      neg_r  <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      neg_r  <= neg_nxt;
    end
  end

endmodule

@@ design/atoi_checker.sv @@
// Port-level checks for the ASCII number converter, bound to the top level.
module atoi_checker
  import atoi_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_char_code,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_number_value,
  input logic        out_is_hex
);

  logic [2:0] pending_r;
  logic       term_in;
  logic       res_out;

  // Count terminators taken against results delivered.
  assign term_in = in_valid && in_ready && (in_char_code == CHAR_NUL);
  assign res_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + {2'b00, term_in} - {2'b00, res_out};
    end
  end

  // A result is shown only for a terminator that has been taken.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pending_r != 3'd0))
    else $error("result shown without a pending terminator");

  // At most one terminator in the input register and one result waiting.
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 3'd2)
    else $error("too many terminators outstanding");

  // The input stalls only behind a result that is not being taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

  // A stalled result keeps its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_number_value) && $stable(out_is_hex)))
    else $error("stalled result changed");

  // Reset leaves no result on the output.
  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind ascii_number_to_integer_core atoi_checker u_atoi_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .in_char_code     (in_chan.char_code),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_number_value (out_chan.number_value),
  .out_is_hex       (out_chan.is_hex)
);
